/* sv/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("implication check failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

`endif

/* sv/gps_pkg.sv */
// shared types, constants and fixed-point helpers for the 4x4 pivot solver
// no dependencies
package gps_pkg;

  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = ROW_COUNT + 1;
  localparam int ENTRIES   = ROW_COUNT * COL_COUNT;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int DIV_STEPS = 48;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic [2:0]         RHS_COL = 3'd4;

  typedef struct packed {
    logic                  wr;
    logic                  solve_req;
    logic [ADDR_W-1:0]     addr;
    logic signed [31:0]    value;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               fault;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [1:0] r, input logic [2:0] k);
    return ADDR_W'({r, 2'b00}) + ADDR_W'(r) + ADDR_W'(k);
  endfunction

  // product shifted down by 16 (floor), saturated
  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = 48'(p >>> 16);
    if (s[47:31] != {17{s[47]}}) return s[47] ? Q_MIN : Q_MAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? Q_MIN : Q_MAX;
    return d[31:0];
  endfunction

endpackage

/* sv/gps_ram.sv */
// generic ram: one write port, two registered read ports
// no dependencies
module gps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/gps_front.sv */
// front end: accepts load items, classifies them, queues them for the back end
// depends on gps_pkg
module gps_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            row_index,
  input  logic [2:0]            col_index,
  input  logic signed [31:0]    entry_value,
  input  logic                  solve_now,
  output logic                  q_valid,
  output gps_pkg::item_t        q_item,
  input  logic                  q_pop
);

  gps_pkg::item_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        // columns past the right-hand side store nothing
        slot[wp].wr        <= (col_index <= gps_pkg::RHS_COL);
        slot[wp].solve_req <= solve_now;
        slot[wp].addr      <= gps_pkg::ent_addr(row_index, col_index);
        slot[wp].value     <= entry_value;
        wp                 <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* sv/gps_div.sv */
// shared fixed-point divider: (a << 16) / b, truncated, saturated, one bit per cycle
// depends on gps_pkg
module gps_div (
  input  logic              clk,
  input  logic              rst,
  input  gps_pkg::div_req_t req,
  output gps_pkg::div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic               fault;
  logic signed [31:0] quo;
  logic [47:0]        num;
  logic [32:0]        rem;
  logic [31:0]        den;
  logic               neg;
  logic [5:0]         cnt;
  logic [31:0]        amag;
  logic [31:0]        bmag;
  logic [32:0]        trial;

  assign amag  = req.a[31] ? 32'(-req.a) : 32'(req.a);
  assign bmag  = req.b[31] ? 32'(-req.b) : 32'(req.b);
  assign trial = {rem[31:0], num[47]};

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.fault = fault;
  assign rsp.quo   = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        if (req.b == '0) begin
          quo   <= req.a[31] ? gps_pkg::Q_MIN : gps_pkg::Q_MAX;
          fault <= 1'b1;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          num  <= {amag, 16'b0};
          rem  <= '0;
          den  <= bmag;
          neg  <= req.a[31] ^ req.b[31];
          cnt  <= '0;
        end
      end else if (busy) begin
        if (cnt == 6'(gps_pkg::DIV_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            fault <= (num > 48'h0000_8000_0000);
            quo   <= (num > 48'h0000_8000_0000) ? gps_pkg::Q_MIN : 32'(-num[31:0]);
          end else begin
            fault <= (num > 48'h0000_7fff_ffff);
            quo   <= (num > 48'h0000_7fff_ffff) ? gps_pkg::Q_MAX : num[31:0];
          end
        end else begin
          cnt <= cnt + 6'd1;
          if (trial >= {1'b0, den}) begin
            rem <= trial - {1'b0, den};
            num <= {num[46:0], 1'b1};
          end else begin
            rem <= trial;
            num <= {num[46:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

/* sv/gps_back.sv */
// back end: stores entries, runs the elimination sequencer, holds the result register
// depends on gps_pkg and gps_ram
module gps_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  gps_pkg::item_t     q_item,
  output logic               q_pop,
  output gps_pkg::div_req_t  div_req,
  input  gps_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] unknown_a,
  output logic signed [31:0] unknown_b,
  output logic signed [31:0] unknown_c,
  output logic signed [31:0] unknown_d,
  output logic signed [31:0] ratio_in_plane,
  output logic signed [31:0] ratio_transverse,
  output logic signed [31:0] modulus_transverse,
  output logic               divide_fault
);

  typedef enum logic [25:0] {
    ST_IDLE    = 26'b1 << 0,
    ST_CP_RD   = 26'b1 << 1,
    ST_CP_WR   = 26'b1 << 2,
    ST_PV_RD   = 26'b1 << 3,
    ST_PV_CMP  = 26'b1 << 4,
    ST_SW_RD   = 26'b1 << 5,
    ST_SW_W1   = 26'b1 << 6,
    ST_SW_W2   = 26'b1 << 7,
    ST_EL_RD   = 26'b1 << 8,
    ST_EL_DIV  = 26'b1 << 9,
    ST_EL_WAIT = 26'b1 << 10,
    ST_MS_RD   = 26'b1 << 11,
    ST_MS_MUL  = 26'b1 << 12,
    ST_MS_WR   = 26'b1 << 13,
    ST_ND_RD   = 26'b1 << 14,
    ST_ND_DIV  = 26'b1 << 15,
    ST_ND_WAIT = 26'b1 << 16,
    ST_BS_RD   = 26'b1 << 17,
    ST_BS_MUL  = 26'b1 << 18,
    ST_BS_WR   = 26'b1 << 19,
    ST_FN_RD0  = 26'b1 << 20,
    ST_FN_RD1  = 26'b1 << 21,
    ST_FN_CAP  = 26'b1 << 22,
    ST_RT_DIV  = 26'b1 << 23,
    ST_RT_WAIT = 26'b1 << 24,
    ST_DONE    = 26'b1 << 25
  } state_t;

  localparam int AW = gps_pkg::ADDR_W;

  state_t             state;
  logic [AW-1:0]      cnt;
  logic [1:0]         c;
  logic [1:0]         r;
  logic [1:0]         i;
  logic [1:0]         big;
  logic [2:0]         k;
  logic [31:0]        bigmag;
  logic signed [31:0] v;
  logic signed [31:0] tmp;
  logic signed [63:0] prod;
  logic               fault;
  logic signed [31:0] res0, res1, res2, res3, res4, res5, res6;

  logic               st_we;
  logic [AW-1:0]      st_waddr;
  logic [31:0]        st_wdata;
  logic [31:0]        st_rdata;
  logic               wk_we;
  logic [AW-1:0]      wk_waddr;
  logic signed [31:0] wk_wdata;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      rb;
  logic signed [31:0] rda;
  logic signed [31:0] rdb;
  logic [31:0]        rd_mag;
  logic signed [31:0] mul_a;
  logic               out_load;

  gps_ram #(.WIDTH(32), .DEPTH(gps_pkg::ENTRIES)) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (cnt),
    .raddr_b (cnt),
    .rdata_a (st_rdata),
    .rdata_b ()
  );

  gps_ram #(.WIDTH(32), .DEPTH(gps_pkg::ENTRIES)) u_work (
    .clk     (clk),
    .we      (wk_we),
    .waddr   (wk_waddr),
    .wdata   (wk_wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rda),
    .rdata_b (rdb)
  );

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign st_we    = q_pop && q_item.wr;
  assign st_waddr = q_item.addr;
  assign st_wdata = q_item.value;
  assign rd_mag   = rda[31] ? 32'(-rda) : 32'(rda);
  assign mul_a    = (state == ST_BS_MUL) ? rda : v;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    wk_we         = 1'b0;
    wk_waddr      = gps_pkg::ent_addr(r, k);
    wk_wdata      = '0;
    ra            = '0;
    rb            = '0;
    div_req.start = 1'b0;
    div_req.a     = rda;
    div_req.b     = rdb;
    unique case (state)
      ST_CP_WR: begin
        wk_we    = 1'b1;
        wk_waddr = cnt;
        wk_wdata = st_rdata;
      end
      ST_PV_RD: ra = gps_pkg::ent_addr(i, {1'b0, c});
      ST_SW_RD: begin
        ra = gps_pkg::ent_addr(c, k);
        rb = gps_pkg::ent_addr(big, k);
      end
      ST_SW_W1: begin
        wk_we    = 1'b1;
        wk_waddr = gps_pkg::ent_addr(c, k);
        wk_wdata = rdb;
      end
      ST_SW_W2: begin
        wk_we    = 1'b1;
        wk_waddr = gps_pkg::ent_addr(big, k);
        wk_wdata = tmp;
      end
      ST_EL_RD: begin
        ra = gps_pkg::ent_addr(r, {1'b0, c});
        rb = gps_pkg::ent_addr(c, {1'b0, c});
      end
      ST_EL_DIV, ST_ND_DIV: div_req.start = 1'b1;
      ST_MS_RD: begin
        ra = gps_pkg::ent_addr(r, k);
        rb = gps_pkg::ent_addr(c, k);
      end
      ST_MS_WR: begin
        wk_we    = 1'b1;
        wk_wdata = gps_pkg::qsub(tmp, gps_pkg::qmul_sat(prod));
      end
      ST_ND_RD: begin
        ra = gps_pkg::ent_addr(i, k);
        rb = gps_pkg::ent_addr(i, {1'b0, i});
      end
      ST_ND_WAIT: begin
        wk_we    = div_rsp.done;
        wk_waddr = gps_pkg::ent_addr(i, k);
        wk_wdata = div_rsp.quo;
      end
      ST_BS_RD: begin
        ra = gps_pkg::ent_addr(i, k);
        rb = gps_pkg::ent_addr(k[1:0], gps_pkg::RHS_COL);
      end
      ST_BS_MUL: ra = gps_pkg::ent_addr(i, gps_pkg::RHS_COL);
      ST_BS_WR: begin
        wk_we    = 1'b1;
        wk_waddr = gps_pkg::ent_addr(i, gps_pkg::RHS_COL);
        wk_wdata = gps_pkg::qsub(rda, gps_pkg::qmul_sat(prod));
      end
      ST_FN_RD0: begin
        ra = gps_pkg::ent_addr(2'd0, gps_pkg::RHS_COL);
        rb = gps_pkg::ent_addr(2'd1, gps_pkg::RHS_COL);
      end
      ST_FN_RD1: begin
        ra = gps_pkg::ent_addr(2'd2, gps_pkg::RHS_COL);
        rb = gps_pkg::ent_addr(2'd3, gps_pkg::RHS_COL);
      end
      ST_RT_DIV: begin
        div_req.start = 1'b1;
        // x0/x1, then x2/x3, then one/x3
        div_req.a = (cnt == AW'(0)) ? res0 : ((cnt == AW'(1)) ? res2 : gps_pkg::Q_ONE);
        div_req.b = (cnt == AW'(0)) ? res1 : res3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.solve_req) begin
            cnt   <= '0;
            fault <= 1'b0;
            state <= ST_CP_RD;
          end
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(gps_pkg::ENTRIES - 1)) begin
            c     <= 2'd0;
            i     <= 2'd0;
            state <= ST_PV_RD;
          end else begin
            state <= ST_CP_RD;
          end
        end
        ST_PV_RD: state <= ST_PV_CMP;
        ST_PV_CMP: begin
          // strict compare keeps the upper row on ties
          if ((i == c) || (bigmag < rd_mag)) begin
            big    <= i;
            bigmag <= rd_mag;
          end
          if (i == 2'd3) begin
            k     <= {1'b0, c};
            state <= ST_SW_RD;
          end else begin
            i     <= i + 2'd1;
            state <= ST_PV_RD;
          end
        end
        ST_SW_RD: state <= ST_SW_W1;
        ST_SW_W1: begin
          tmp   <= rda;
          state <= ST_SW_W2;
        end
        ST_SW_W2: begin
          if (k == gps_pkg::RHS_COL) begin
            r     <= c + 2'd1;
            state <= ST_EL_RD;
          end else begin
            k     <= k + 3'd1;
            state <= ST_SW_RD;
          end
        end
        ST_EL_RD:  state <= ST_EL_DIV;
        ST_EL_DIV: state <= ST_EL_WAIT;
        ST_EL_WAIT: begin
          if (div_rsp.done) begin
            v     <= div_rsp.quo;
            fault <= fault | div_rsp.fault;
            k     <= {1'b0, c};
            state <= ST_MS_RD;
          end
        end
        ST_MS_RD: state <= ST_MS_MUL;
        ST_MS_MUL: begin
          prod  <= mul_a * rdb;
          tmp   <= rda;
          state <= ST_MS_WR;
        end
        ST_MS_WR: begin
          if (k == gps_pkg::RHS_COL) begin
            if (r == 2'd3) begin
              if (c == 2'd2) begin
                i     <= 2'd0;
                k     <= gps_pkg::RHS_COL;
                state <= ST_ND_RD;
              end else begin
                c     <= c + 2'd1;
                i     <= c + 2'd1;
                state <= ST_PV_RD;
              end
            end else begin
              r     <= r + 2'd1;
              state <= ST_EL_RD;
            end
          end else begin
            k     <= k + 3'd1;
            state <= ST_MS_RD;
          end
        end
        ST_ND_RD:  state <= ST_ND_DIV;
        ST_ND_DIV: state <= ST_ND_WAIT;
        ST_ND_WAIT: begin
          if (div_rsp.done) begin
            fault <= fault | div_rsp.fault;
            // diagonal goes last so the row sees the old pivot
            if (k == {1'b0, i}) begin
              if (i == 2'd3) begin
                i     <= 2'd2;
                k     <= 3'd3;
                state <= ST_BS_RD;
              end else begin
                i     <= i + 2'd1;
                k     <= gps_pkg::RHS_COL;
                state <= ST_ND_RD;
              end
            end else begin
              k     <= k - 3'd1;
              state <= ST_ND_RD;
            end
          end
        end
        ST_BS_RD: state <= ST_BS_MUL;
        ST_BS_MUL: begin
          prod  <= mul_a * rdb;
          state <= ST_BS_WR;
        end
        ST_BS_WR: begin
          if (k == ({1'b0, i} + 3'd1)) begin
            if (i == 2'd0) begin
              state <= ST_FN_RD0;
            end else begin
              i     <= i - 2'd1;
              k     <= 3'd3;
              state <= ST_BS_RD;
            end
          end else begin
            k     <= k - 3'd1;
            state <= ST_BS_RD;
          end
        end
        ST_FN_RD0: state <= ST_FN_RD1;
        ST_FN_RD1: begin
          res0  <= rda;
          res1  <= rdb;
          state <= ST_FN_CAP;
        end
        ST_FN_CAP: begin
          res2  <= rda;
          res3  <= rdb;
          cnt   <= '0;
          state <= ST_RT_DIV;
        end
        ST_RT_DIV: state <= ST_RT_WAIT;
        ST_RT_WAIT: begin
          if (div_rsp.done) begin
            fault <= fault | div_rsp.fault;
            case (cnt)
              AW'(0):  res4 <= div_rsp.quo;
              AW'(1):  res5 <= div_rsp.quo;
              default: res6 <= div_rsp.quo;
            endcase
            if (cnt == AW'(2)) begin
              state <= ST_DONE;
            end else begin
              cnt   <= cnt + AW'(1);
              state <= ST_RT_DIV;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      unknown_a          <= res0;
      unknown_b          <= res1;
      unknown_c          <= res2;
      unknown_d          <= res3;
      ratio_in_plane     <= res4;
      ratio_transverse   <= res5;
      modulus_transverse <= res6;
      divide_fault       <= fault;
    end
  end

endmodule

/* sv/gauss_pivot_solver_4x4_top.sv */
// Fixed-point 4x4 linear solver with partial pivoting. Load items write one Q16.16
// entry of the 4x5 augmented matrix; a load item is queued in the front end and
// written to the store when the back end is idle, and a two-entry queue lets the
// front keep accepting while the back is busy, until the queue is full. An item
// with solve_now set stores its entry, then runs a solve: it copies the store into
// the working matrix, then makes 23 divisions on the shared radix-2 divider, plus
// the multiply-subtract steps on the single working-matrix ram. The result waits in
// an output register; the next solve cannot finish until that register has been taken.
// depends on gps_pkg, gps_front, gps_back, gps_div, assert_macros.svh
`include "assert_macros.svh"

module gauss_pivot_solver_4x4_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] entry_value,
  input  logic               solve_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] unknown_a,
  output logic signed [31:0] unknown_b,
  output logic signed [31:0] unknown_c,
  output logic signed [31:0] unknown_d,
  output logic signed [31:0] ratio_in_plane,
  output logic signed [31:0] ratio_transverse,
  output logic signed [31:0] modulus_transverse,
  output logic               divide_fault
);

  logic              q_valid;
  logic              q_pop;
  gps_pkg::item_t    q_item;
  gps_pkg::div_req_t div_req;
  gps_pkg::div_rsp_t div_rsp;

  gps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .solve_now   (solve_now),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  gps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gps_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .unknown_a          (unknown_a),
    .unknown_b          (unknown_b),
    .unknown_c          (unknown_c),
    .unknown_d          (unknown_d),
    .ratio_in_plane     (ratio_in_plane),
    .ratio_transverse   (ratio_transverse),
    .modulus_transverse (modulus_transverse),
    .divide_fault       (divide_fault)
  );

  // the sequencer never issues a division while one is in flight
  `ASSERT_IMPLIES(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy)
  // a division completes with a single-cycle pulse
  `ASSERT_NEXT(a_div_done_pulse, clk, rst, div_rsp.done, !div_rsp.done)
  // the back end only takes a transaction that the queue holds
  `ASSERT_IMPLIES(a_pop_valid, clk, rst, q_pop, q_valid)

endmodule

/* sim/gauss_pivot_solver_4x4_top_tb.sv */
// testbench for gauss_pivot_solver_4x4_top: loads random augmented matrices, predicts each solve
// in fixed point and checks the emitted unknowns, quotients and fault flag
// depends on gps_pkg and gauss_pivot_solver_4x4_top
`timescale 1ns / 100ps

module gauss_pivot_solver_4x4_top_tb;

  localparam int  NUM_RANDOM  = 900;
  localparam int  CYCLE_LIMIT = 8000000;
  localparam int  HOLD_CYCLES = 5000;
  localparam int  HOLD_AT     = 650;
  localparam int  DRAIN_WAIT  = 1500;

  typedef enum int {MODE_SLOW_RX, MODE_SLOW_TX, MODE_FULL} idle_mode_e;

  typedef struct {
    logic [1:0]         row;
    logic [2:0]         col;
    logic signed [31:0] val;
    logic               solve_req;
  } load_t;

  typedef struct {
    logic signed [31:0] x[4];
    logic signed [31:0] r_ip;
    logic signed [31:0] r_tr;
    logic signed [31:0] mod_tr;
    logic               fault;
  } solution_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] row_index = 0;
  logic [2:0] col_index = 0;
  logic signed [31:0] entry_value = 0;
  logic solve_now = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] unknown_a, unknown_b, unknown_c, unknown_d;
  logic signed [31:0] ratio_in_plane, ratio_transverse, modulus_transverse;
  logic divide_fault;

  load_t      pending_loads[$];
  solution_t  expected_solutions[$];
  logic signed [31:0] matrix_store[4][5];
  bit         div_fault_acc;
  int         accepted_loads = 0;
  int         errors = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 0;
  idle_mode_e idle_mode;

  gauss_pivot_solver_4x4_top u_top (.*);

  always #2 clk = ~clk;

  assign idle_mode = (accepted_loads < 320) ? MODE_SLOW_RX :
                     (accepted_loads < 620) ? MODE_SLOW_TX : MODE_FULL;

  function automatic logic signed [31:0] sat32(longint v, output bit hit);
    hit = 0;
    if (v > longint'(gps_pkg::Q_MAX)) begin
      hit = 1;
      return gps_pkg::Q_MAX;
    end
    if (v < longint'(gps_pkg::Q_MIN)) begin
      hit = 1;
      return gps_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    bit h;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 16, h);
  endfunction

  function automatic logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
    bit h;
    return sat32(longint'(a) - longint'(b), h);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
    bit h;
    logic signed [31:0] q;
    if (b == 0) begin
      div_fault_acc = 1;
      return (a < 0) ? gps_pkg::Q_MIN : gps_pkg::Q_MAX;
    end
    q = sat32((longint'(a) * 65536) / longint'(b), h);
    if (h) div_fault_acc = 1;
    return q;
  endfunction

  function automatic longint magnitude(logic signed [31:0] a);
    return (a < 0) ? -longint'(a) : longint'(a);
  endfunction

  // pivoted elimination, row normalization, back-substitution, then the final quotients
  task automatic solve_system(output solution_t s);
    logic signed [31:0] m[4][5];
    logic signed [31:0] t, v;
    int big;
    m = matrix_store;
    div_fault_acc = 0;
    for (int c = 0; c < 3; c++) begin
      big = c;
      for (int i = c + 1; i < 4; i++)
        if (magnitude(m[big][c]) < magnitude(m[i][c])) big = i;
      for (int k = c; k < 5; k++) begin
        t = m[c][k];
        m[c][k] = m[big][k];
        m[big][k] = t;
      end
      for (int r = c + 1; r < 4; r++) begin
        v = fx_div(m[r][c], m[c][c]);
        for (int k = c; k < 5; k++) m[r][k] = fx_sub(m[r][k], fx_mul(v, m[c][k]));
      end
    end
    for (int i = 0; i < 4; i++)
      for (int j = 4; j >= i; j--) m[i][j] = fx_div(m[i][j], m[i][i]);
    for (int i = 2; i >= 0; i--)
      for (int k = 3; k > i; k--) m[i][4] = fx_sub(m[i][4], fx_mul(m[i][k], m[k][4]));
    for (int i = 0; i < 4; i++) s.x[i] = m[i][4];
    s.r_ip   = fx_div(s.x[0], s.x[1]);
    s.r_tr   = fx_div(s.x[2], s.x[3]);
    s.mod_tr = fx_div(gps_pkg::Q_ONE, s.x[3]);
    s.fault  = div_fault_acc;
  endtask

  task automatic apply_load(load_t ld);
    solution_t s;
    if (ld.col < 5) matrix_store[ld.row][ld.col] = ld.val;
    if (ld.solve_req) begin
      solve_system(s);
      expected_solutions.push_back(s);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 0;
      2: return $urandom_range(0, 1) ? gps_pkg::Q_MAX : gps_pkg::Q_MIN;
      3: return $urandom_range(0, 1) ? gps_pkg::Q_ONE : -gps_pkg::Q_ONE;
      default: return $signed($urandom_range(0, 1048576)) - 524288;
    endcase
  endfunction

  task automatic queue_load(int r, int k, logic signed [31:0] v, bit s);
    load_t ld;
    ld.row = 2'(r);
    ld.col = 3'(k);
    ld.val = v;
    ld.solve_req = s;
    pending_loads.push_back(ld);
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin
    load_t ld;
    bit idle;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        ld.row = row_index;
        ld.col = col_index;
        ld.val = entry_value;
        ld.solve_req = solve_now;
        apply_load(ld);
        accepted_loads++;
      end
      if (!in_valid || !in_stall) begin
        case (idle_mode)
          MODE_SLOW_RX: idle = ($urandom_range(0, 99) < 7);
          MODE_SLOW_TX: idle = ($urandom_range(0, 99) < 85);
          default:      idle = 0;
        endcase
        if (pending_loads.size() != 0 && !idle) begin
          ld = pending_loads.pop_front();
          row_index   <= ld.row;
          col_index   <= ld.col;
          entry_value <= ld.val;
          solve_now   <= ld.solve_req;
          in_valid    <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off so the load queue backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_loads >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    solution_t s;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_solutions.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          s = expected_solutions.pop_front();
          check_field("unknown_a", s.x[0], unknown_a);
          check_field("unknown_b", s.x[1], unknown_b);
          check_field("unknown_c", s.x[2], unknown_c);
          check_field("unknown_d", s.x[3], unknown_d);
          check_field("ratio_in_plane", s.r_ip, ratio_in_plane);
          check_field("ratio_transverse", s.r_tr, ratio_transverse);
          check_field("modulus_transverse", s.mod_tr, modulus_transverse);
          check_field("divide_fault", 32'(s.fault), 32'(divide_fault));
        end
      end
      case (idle_mode)
        MODE_SLOW_RX: out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < 85);
        MODE_SLOW_TX: out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < 7);
        default:      out_stall <= (hold_left != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gauss_pivot_solver_4x4_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int order[20];
    int n, j, t, k;
    // directed: extremes over a diagonally heavy matrix
    for (int i = 0; i < 20; i++) begin
      case (i % 5)
        4:       t = (i / 5) % 2 ? gps_pkg::Q_MIN : gps_pkg::Q_MAX;
        default: t = ((i % 5) == (i / 5)) ? 4 * gps_pkg::Q_ONE :
                     ((i % 3) ? -gps_pkg::Q_ONE : 1);
      endcase
      queue_load(i / 5, i % 5, t, i == 19);
    end
    // out-of-range column still triggers a solve
    queue_load(3, 7, gps_pkg::Q_MAX, 1);
    // zero first column forces zero pivot, also a pivot tie
    for (int r = 0; r < 4; r++) queue_load(r, 0, 0, r == 3);

    n = 0;
    while (n < NUM_RANDOM) begin
      if ($urandom_range(0, 99) < 70) begin
        // fresh matrix in shuffled order
        for (int i = 0; i < 20; i++) order[i] = i;
        for (int i = 19; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (int i = 0; i < 20; i++) begin
          t = pick_value();
          if (order[i] % 5 == order[i] / 5 && $urandom_range(0, 3) != 0)
            t = t + ($urandom_range(0, 1) ? 8 * gps_pkg::Q_ONE : -8 * gps_pkg::Q_ONE);
          queue_load(order[i] / 5, order[i] % 5, t, i == 19);
        end
        n += 20;
      end else begin
        // partial update with some noise
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0)
            queue_load($urandom_range(0, 3), $urandom_range(5, 7), $urandom,
                       $urandom_range(0, 1));
          else
            queue_load($urandom_range(0, 3), $urandom_range(0, 4), pick_value(), i == k - 1);
        end
        n += k;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 0;
    while (pending_loads.size() != 0 || in_valid || expected_solutions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("gauss_pivot_solver_4x4_top_tb: done, clean");
    else
      $display("gauss_pivot_solver_4x4_top_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/gps_pkg.sv
sv/gps_ram.sv
sv/gps_front.sv
sv/gps_div.sv
sv/gps_back.sv
sv/gauss_pivot_solver_4x4_top.sv
sim/gauss_pivot_solver_4x4_top_tb.sv
